// ===== src/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// shared types, constants and helper of the line substring filter
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned LineCharsDef  = 63;
  localparam int unsigned PatternMaxDef = 8;

  localparam logic [7:0] NewlineCode = 8'h0A;
  localparam logic [7:0] ZeroByte    = 8'h00;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PATTERN = 2'd0,
    CFG_LEN     = 2'd1,
    CFG_INVERT  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_e;

  // control state of the line sequencer
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_LOAD,
    ST_NEWLINE,
    ST_STATUS
  } lsf_state_e;

  // window control handed to the matcher
  typedef struct packed {
    logic shift;
    logic clear;
  } lsf_mctl_t;

  // pattern length in use: saturated, then cut at the first zero byte
  function automatic logic [3:0] active_len(logic [63:0] pb, logic [3:0] pl,
                                            logic [3:0] pmax);
    logic [3:0] n;
    logic [3:0] res;
    n   = (pl > pmax) ? pmax : pl;
    res = n;
    for (int i = 7; i >= 0; i--) begin
      if ((4'(i) < n) && (pb[8*i +: 8] == ZeroByte)) begin
        res = 4'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== src/lsf_line_buf.sv =====
// ----------------------------------------------------------------------------
// lsf_line_buf
// line store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lsf_line_buf #(
  parameter int unsigned Depth = 63,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/lsf_matcher.sv =====
// ----------------------------------------------------------------------------
// lsf_matcher
// sliding window over the visible bytes of a line and pattern compare
// ----------------------------------------------------------------------------
module lsf_matcher
  import lsf_pkg::*;
#(
  parameter int unsigned PatternMax = PatternMaxDef,
  parameter int unsigned LenW       = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lsf_mctl_t       ctl_i,
  input  logic [7:0]      ch_i,
  input  logic [LenW-1:0] vis_new_i,
  input  logic [63:0]     pattern_i,
  input  logic [3:0]      pattern_len_i,
  output logic [3:0]      act_len_o,
  output logic            matched_o
);

  localparam int unsigned WinW = PatternMax * 8;

  logic [WinW-1:0]   win_q, win_d;
  logic              matched_q, matched_d;
  logic [WinW+7:0]   ext;
  logic [WinW-1:0]   cur;
  logic              eq;

  assign act_len_o = active_len(pattern_i, pattern_len_i, 4'(PatternMax));
  assign ext       = {win_q, ch_i};
  assign cur       = ext[WinW-1:0];

  // newest byte against the last pattern byte, and so on back
  always_comb begin
    logic [2:0] idx;
    eq = 1'b1;
    for (int k = 0; k < int'(PatternMax); k++) begin
      idx = 3'(act_len_o - 4'(k) - 4'd1);
      if ((4'(k) < act_len_o) && (cur[8*k +: 8] != pattern_i[{idx, 3'b000} +: 8])) begin
        eq = 1'b0;
      end
    end
  end

  always_comb begin
    win_d     = win_q;
    matched_d = matched_q;
    if (ctl_i.clear) begin
      win_d     = '0;
      matched_d = 1'b0;
    end else if (ctl_i.shift) begin
      win_d = cur;
      if ((act_len_o != 4'd0) && (vis_new_i >= LenW'(act_len_o)) && eq) begin
        matched_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      matched_q <= 1'b0;
    end else begin
      win_q     <= win_d;
      matched_q <= matched_d;
    end
  end

  assign matched_o = matched_q;

endmodule

// ===== src/line_substring_filter.sv =====
// ----------------------------------------------------------------------------
// line_substring_filter
// fixed-string line filter: stores each line, tests it for the pattern and
// replays the selected lines followed by a newline
// ----------------------------------------------------------------------------
// a byte that ends no line, or a newline ending a dropped line, gives no word
// a selected line of V visible bytes replays after its newline: a line store
// read to start, one byte per cycle from the read port while the output is free,
// newline; end of input adds one status word unless its line is selected, whose
// newline carries stream_done; reset clears control, length counters, window,
// flags; the line store is not cleared, only entries of the current line are read
module line_substring_filter
  import lsf_pkg::*;
#(
  parameter int unsigned LINE_CHARS  = LineCharsDef,
  parameter int unsigned PATTERN_MAX = PatternMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,   // end_of_input
  // output byte stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,   // last
  output logic [2:0]  m_axis_tuser_o    // [0] has_byte, [1] stream_done, [2] found
);

  localparam int unsigned LenW  = $clog2(LINE_CHARS + 1);
  localparam int unsigned AddrW = $clog2(LINE_CHARS);

  // configuration registers
  logic [63:0] pattern_q;
  logic [3:0]  plen_q;
  logic        invert_q;

  // line state
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] vis_q, vis_d;
  logic            zero_q, zero_d;
  logic            any_q, any_d;

  // replay state
  lsf_state_e      state_q, state_d;
  logic [LenW-1:0] rd_addr_q, rd_addr_d;
  logic [LenW-1:0] end_q, end_d;
  logic            eoi_q, eoi_d;
  logic            found_q, found_d;

  // output register
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_data_q, m_data_d;
  logic       m_last_q, m_last_d;
  logic [2:0] m_user_q, m_user_d;

  logic       in_acc;
  logic       is_eoi;
  logic       is_nl;
  logic       out_free;
  logic       out_load;
  logic       wr_en;
  logic       rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0] rd_data;
  logic       hit;
  logic       emit;
  logic       found_n;
  logic [3:0] act_len;
  logic       matched;
  lsf_mctl_t  mctl;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_COLLECT);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_eoi          = s_axis_tlast_i;
  assign is_nl           = !is_eoi && (s_axis_tdata_i == NewlineCode);
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // line evaluation at its terminator
  assign hit     = (act_len == 4'd0) || matched;
  assign emit    = (len_q != '0) && (hit != invert_q);
  assign found_n = any_q || ((len_q != '0) && hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
      invert_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PATTERN: pattern_q <= cfg_data_i;
        CFG_LEN:     plen_q    <= cfg_data_i[3:0];
        CFG_INVERT:  invert_q  <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  // byte intake: store, track visible part, drive the matcher
  always_comb begin
    len_d      = len_q;
    vis_d      = vis_q;
    zero_d     = zero_q;
    any_d      = any_q;
    wr_en      = 1'b0;
    mctl.shift = 1'b0;
    mctl.clear = 1'b0;
    end_d      = end_q;
    eoi_d      = eoi_q;
    found_d    = found_q;
    if (in_acc) begin
      if (is_eoi || is_nl) begin
        len_d      = '0;
        vis_d      = '0;
        zero_d     = 1'b0;
        mctl.clear = 1'b1;
        end_d      = vis_q;
        eoi_d      = is_eoi;
        found_d    = found_n;
        any_d      = is_eoi ? 1'b0 : found_n;
      end else if (len_q < LenW'(LINE_CHARS)) begin
        wr_en = 1'b1;
        len_d = len_q + LenW'(1);
        if (!zero_q) begin
          if (s_axis_tdata_i == ZeroByte) begin
            zero_d = 1'b1;
          end else begin
            vis_d      = vis_q + LenW'(1);
            mctl.shift = 1'b1;
          end
        end
      end
    end
  end

  // replay sequencer
  always_comb begin
    state_d   = state_q;
    rd_addr_d = rd_addr_q;
    rd_en     = 1'b0;
    rd_addr   = rd_addr_q[AddrW-1:0];
    out_load  = 1'b0;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_user_d  = m_user_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc && (is_eoi || is_nl)) begin
          if (emit) begin
            if (vis_q == '0) begin
              state_d = ST_NEWLINE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              rd_addr_d = LenW'(1);
              state_d   = ST_LOAD;
            end
          end else if (is_eoi) begin
            state_d = ST_STATUS;
          end
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          m_data_d = rd_data;
          m_last_d = 1'b0;
          m_user_d = {found_q, 1'b0, 1'b1};
          if (rd_addr_q == end_q) begin
            state_d = ST_NEWLINE;
          end else begin
            rd_en     = 1'b1;
            rd_addr_d = rd_addr_q + LenW'(1);
          end
        end
      end
      ST_NEWLINE: begin
        if (out_free) begin
          out_load = 1'b1;
          m_data_d = NewlineCode;
          m_last_d = 1'b1;
          m_user_d = {found_q, eoi_q, 1'b1};
          state_d  = ST_COLLECT;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_load = 1'b1;
          m_data_d = ZeroByte;
          m_last_d = 1'b1;
          m_user_d = {found_q, 1'b1, 1'b0};
          state_d  = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      len_q     <= '0;
      vis_q     <= '0;
      zero_q    <= 1'b0;
      any_q     <= 1'b0;
      rd_addr_q <= '0;
      end_q     <= '0;
      eoi_q     <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      vis_q     <= vis_d;
      zero_q    <= zero_d;
      any_q     <= any_d;
      rd_addr_q <= rd_addr_d;
      end_q     <= end_d;
      eoi_q     <= eoi_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

  lsf_line_buf #(
    .Depth (LINE_CHARS),
    .AddrW (AddrW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (len_q[AddrW-1:0]),
    .wr_data_i (s_axis_tdata_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lsf_matcher #(
    .PatternMax (PATTERN_MAX),
    .LenW       (LenW)
  ) u_matcher (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (mctl),
    .ch_i          (s_axis_tdata_i),
    .vis_new_i     (vis_d),
    .pattern_i     (pattern_q),
    .pattern_len_i (plen_q),
    .act_len_o     (act_len),
    .matched_o     (matched)
  );

`ifndef SYNTHESIS
  // replay never reads past the visible part of the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (rd_addr_q <= end_q) && (rd_addr_q != '0))
    else $error("replay address out of range");

  // stream end marker only on the final word of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q[1]) |-> m_last_q)
    else $error("stream_done without last");

  // a word without a byte is always the end-of-input status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q[0]) |-> (m_user_q[1] && m_last_q))
    else $error("status word not marked as stream end");

  // end of input clears the sticky match flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_eoi) |=> !any_q)
    else $error("match flag survived end of input");
`endif

endmodule
